@@ rtl/jsu_pkg.sv @@
`default_nettype none
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_HEX    = 3'd2,
    MODE_HI     = 3'd3,
    MODE_HI_ESC = 3'd4,
    MODE_HI_HEX = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_DONE   = 3'd1,
    KIND_BADESC = 3'd2,
    KIND_BADU   = 3'd3,
    KIND_UNTERM = 3'd4
  } kind_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  localparam logic [15:0] HI_SURR_MIN = 16'hD800;
  localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  localparam int NUM_SLOTS = 8;
  localparam int TAIL_SLOT = 7;

  // One input's worth of work: an optional held surrogate, an optional
  // code point, and an optional trailing byte or status.
  typedef struct packed {
    logic        held_en;
    logic [15:0] held;
    logic        cp_en;
    logic [20:0] cp;
    logic        tail_en;
    logic [7:0]  tail_byte;
    kind_t       tail_kind;
  } job_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } result_t;

  function automatic logic [3:0][7:0] utf8_bytes(input logic [20:0] cp);
    logic [3:0][7:0] b;
    b = '0;
    if (cp <= 21'h7F) begin
      b[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      b[0] = {3'b110, cp[10:6]};
      b[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      b[0] = {4'b1110, cp[15:12]};
      b[1] = {2'b10, cp[11:6]};
      b[2] = {2'b10, cp[5:0]};
    end else begin
      b[0] = {5'b11110, cp[20:18]};
      b[1] = {2'b10, cp[17:12]};
      b[2] = {2'b10, cp[11:6]};
      b[3] = {2'b10, cp[5:0]};
    end
    return b;
  endfunction

  function automatic logic [3:0] utf8_mask(input logic [20:0] cp);
    logic [3:0] m;
    if (cp <= 21'h7F) begin
      m = 4'b0001;
    end else if (cp <= 21'h7FF) begin
      m = 4'b0011;
    end else if (cp <= 21'hFFFF) begin
      m = 4'b0111;
    end else begin
      m = 4'b1111;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

@@ rtl/jsu_fifo.sv @@
`default_nettype none
module jsu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr & ~do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd & ~do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end
endmodule
`default_nettype wire

@@ rtl/jsu_front.sv @@
`default_nettype none
module jsu_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         accept,
  input  wire logic [7:0]   in_byte,
  input  wire logic         in_source_end,
  output logic              job_push,
  output jsu_pkg::job_t     job
);
  import jsu_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [15:0] held_r, held_nxt;

  logic        hex_ok;
  logic [3:0]  hex_d;
  logic [15:0] acc_sh;
  logic        hex_done, is_hi, is_lo, pair;
  logic        esc_ok;
  logic [7:0]  esc_byte;
  logic [7:0]  norm_byte, sesc_byte;
  kind_t       norm_kind, sesc_kind;

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = '0;
    case (in_byte) inside
      [8'h30:8'h39]: hex_d = in_byte[3:0];
      [8'h61:8'h66], [8'h41:8'h46]: hex_d = in_byte[3:0] + 4'd9;
      default: hex_ok = 1'b0;
    endcase
  end

  assign acc_sh   = {acc_r[11:0], hex_d};
  assign hex_done = hex_ok & (cnt_r == 2'd3);
  assign is_hi    = (acc_sh >= HI_SURR_MIN) && (acc_sh <= HI_SURR_MAX);
  assign is_lo    = (acc_sh >= LO_SURR_MIN) && (acc_sh <= LO_SURR_MAX);
  assign pair     = (mode_r == MODE_HI_HEX) & is_lo;

  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = in_byte;
    case (in_byte)
      CH_QUOTE, CH_BSLASH, CH_SLASH: esc_byte = in_byte;
      CH_B: esc_byte = 8'h08;
      CH_F: esc_byte = 8'h0C;
      CH_N: esc_byte = 8'h0A;
      CH_R: esc_byte = 8'h0D;
      CH_T: esc_byte = 8'h09;
      default: esc_ok = 1'b0;
    endcase
  end

  assign norm_kind = (in_byte == CH_QUOTE) ? KIND_DONE : KIND_DATA;
  assign norm_byte = (in_byte == CH_QUOTE) ? 8'h00 : in_byte;
  assign sesc_kind = esc_ok ? KIND_DATA : KIND_BADESC;
  assign sesc_byte = esc_ok ? esc_byte : 8'h00;

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    held_nxt = held_r;
    if (accept) begin
      if (in_source_end) begin
        mode_nxt = MODE_IDLE;
        cnt_nxt  = '0;
      end else begin
        case (mode_r)
          MODE_ESC, MODE_HI_ESC: begin
            if (in_byte == CH_U) begin
              mode_nxt = (mode_r == MODE_ESC) ? MODE_HEX : MODE_HI_HEX;
              cnt_nxt  = '0;
              acc_nxt  = '0;
            end else begin
              mode_nxt = MODE_IDLE;
            end
          end
          MODE_HEX, MODE_HI_HEX: begin
            if (!hex_ok) begin
              mode_nxt = MODE_IDLE;
              cnt_nxt  = '0;
            end else begin
              acc_nxt = acc_sh;
              if (hex_done) begin
                cnt_nxt = '0;
                if (!pair && is_hi) begin
                  held_nxt = acc_sh;
                  mode_nxt = MODE_HI;
                end else begin
                  mode_nxt = MODE_IDLE;
                end
              end else begin
                cnt_nxt = cnt_r + 2'd1;
              end
            end
          end
          MODE_HI: begin
            mode_nxt = (in_byte == CH_BSLASH) ? MODE_HI_ESC : MODE_IDLE;
          end
          default: begin
            mode_nxt = (in_byte == CH_BSLASH) ? MODE_ESC : MODE_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    job      = '0;
    job.held = held_r;
    if (accept) begin
      if (in_source_end) begin
        job.held_en   = (mode_r == MODE_HI) || (mode_r == MODE_HI_ESC) ||
                        (mode_r == MODE_HI_HEX);
        job.tail_en   = 1'b1;
        job.tail_kind = ((mode_r == MODE_HEX) || (mode_r == MODE_HI_HEX)) ?
                        KIND_BADU : KIND_UNTERM;
      end else begin
        case (mode_r)
          MODE_ESC, MODE_HI_ESC: begin
            if (in_byte != CH_U) begin
              job.held_en   = (mode_r == MODE_HI_ESC);
              job.tail_en   = 1'b1;
              job.tail_kind = sesc_kind;
              job.tail_byte = sesc_byte;
            end
          end
          MODE_HEX, MODE_HI_HEX: begin
            if (!hex_ok) begin
              job.held_en   = (mode_r == MODE_HI_HEX);
              job.tail_en   = 1'b1;
              job.tail_kind = KIND_BADU;
            end else if (hex_done) begin
              if (pair) begin
                job.cp_en = 1'b1;
                job.cp    = SUPP_BASE + {1'b0, held_r[9:0], acc_sh[9:0]};
              end else begin
                job.held_en = (mode_r == MODE_HI_HEX);
                job.cp_en   = ~is_hi;
                job.cp      = {5'b0, acc_sh};
              end
            end
          end
          MODE_HI: begin
            if (in_byte != CH_BSLASH) begin
              job.held_en   = 1'b1;
              job.tail_en   = 1'b1;
              job.tail_kind = norm_kind;
              job.tail_byte = norm_byte;
            end
          end
          default: begin
            if (in_byte != CH_BSLASH) begin
              job.tail_en   = 1'b1;
              job.tail_kind = norm_kind;
              job.tail_byte = norm_byte;
            end
          end
        endcase
      end
    end
  end

  assign job_push = job.held_en | job.cp_en | job.tail_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      cnt_r  <= '0;
      acc_r  <= '0;
      held_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      held_r <= held_nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/jsu_back.sv @@
`default_nettype none
module jsu_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire jsu_pkg::job_t   job_head,
  input  wire logic            job_avail,
  output logic                 job_pop,
  output logic                 res_push,
  output jsu_pkg::result_t     res,
  input  wire logic            res_full
);
  import jsu_pkg::*;

  job_t                  job_r, job_nxt;
  logic [NUM_SLOTS-1:0]  mask_r, mask_nxt;
  logic [NUM_SLOTS-1:0]  rem, head_mask;
  logic [3:0][7:0]       held_b, cp_b;
  logic [7:0]            slot_byte [NUM_SLOTS];
  logic [2:0]            sel;
  logic                  emit, last, load;

  assign head_mask = {job_head.tail_en, utf8_mask(job_head.cp) & {4{job_head.cp_en}},
                      {3{job_head.held_en}}};

  assign held_b = utf8_bytes({5'b0, job_r.held});
  assign cp_b   = utf8_bytes(job_r.cp);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      slot_byte[i] = held_b[i];
    end
    for (int i = 0; i < 4; i++) begin
      slot_byte[i + 3] = cp_b[i];
    end
    slot_byte[TAIL_SLOT] = job_r.tail_byte;
  end

  always_comb begin
    sel = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = 3'(i);
      end
    end
  end

  assign rem  = mask_r & (mask_r - 1'b1);
  assign last = (rem == '0);
  assign emit = (mask_r != '0) & ~res_full;
  assign load = job_avail & ((mask_r == '0) | (emit & last));

  assign job_pop   = load;
  assign res_push  = emit;
  assign res.data  = slot_byte[sel];
  assign res.kind  = (sel == 3'(TAIL_SLOT)) ? job_r.tail_kind : KIND_DATA;
  assign res.last  = last;

  always_comb begin
    job_nxt  = job_r;
    mask_nxt = mask_r;
    if (load) begin
      job_nxt  = job_head;
      mask_nxt = head_mask;
    end else if (emit) begin
      mask_nxt = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end
endmodule
`default_nettype wire

@@ rtl/json_string_unescape_utf8.sv @@
// JSON string body unescaper with UTF-8 output.
// Input channel: a queue write port. Drive in_byte/in_source_end with push;
// an item is taken on a clock edge with push high and full low. Feed the bytes
// that follow the opening quote; in_source_end marks the source as exhausted.
// Result channel: a queue read port. While empty is low, out_byte, out_kind
// and out_last show the oldest result; pop takes it. out_last marks the
// final result caused by one input item; an item may cause none.
// Throughput: one input item per cycle while full is low; results leave at one
// per cycle while the result queue has room, so an item that expands into n
// results (up to 6, for a held surrogate followed by a 3-byte character) is
// absorbed by the job queue (JOB_DEPTH) and the result queue (OUT_DEPTH).
// An accepted item is held in the job queue, the back-end job register and
// then the result queue. When the receiver stalls, the result queue and then
// the job queue fill and full rises; nothing is dropped. Reset (rst_n low,
// synchronous) empties both queues and returns the decoder to its idle state.
`default_nettype none
module json_string_unescape_utf8 #(
  parameter int JOB_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_source_end,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic [2:0]      out_kind,
  output logic            out_last
);
  import jsu_pkg::*;

  logic    accept, job_push, job_pop, jq_empty, res_push, res_full;
  job_t    job_in, job_head;
  result_t res_in, res_out;

  assign accept = push & ~full;

  jsu_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_byte       (in_byte),
    .in_source_end (in_source_end),
    .job_push      (job_push),
    .job           (job_in)
  );

  jsu_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_data (job_in),
    .full    (full),
    .rd_en   (job_pop),
    .rd_data (job_head),
    .empty   (jq_empty)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_head  (job_head),
    .job_avail (~jq_empty),
    .job_pop   (job_pop),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  jsu_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign out_byte = res_out.data;
  assign out_kind = res_out.kind;
  assign out_last = res_out.last;
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import jsu_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } decoded_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       src_end;
  } src_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       in_source_end = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] out_kind;
  logic       out_last;

  json_string_unescape_utf8 DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .in_source_end(in_source_end),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .out_kind     (out_kind),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  src_item_t  source_q[$];
  decoded_t   decoded_q[$];
  decoded_t   step_q[$];

  mode_t       dec_mode = MODE_IDLE;
  logic [1:0]  hex_cnt = 2'd0;
  logic [15:0] code_acc = 16'h0000;
  logic [15:0] held_hi = 16'h0000;

  int errors = 0;
  int items_taken = 0;
  int results_checked = 0;
  int status_seen = 0;
  int full_cycles = 0;

  function automatic logic [4:0] hex_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
    return 5'd16;
  endfunction

  function automatic void put_res(logic [7:0] b, kind_t k);
    if (step_q.size() < 6) step_q.push_back('{data: b, kind: k, last: 1'b0});
  endfunction

  function automatic void put_utf8(logic [20:0] cp);
    if (cp <= 21'h7F) begin
      put_res(cp[7:0], KIND_DATA);
    end else if (cp <= 21'h7FF) begin
      put_res(8'hC0 | 8'(cp >> 6), KIND_DATA);
      put_res(8'h80 | 8'(cp & 21'h3F), KIND_DATA);
    end else if (cp <= 21'hFFFF) begin
      put_res(8'hE0 | 8'(cp >> 12), KIND_DATA);
      put_res(8'h80 | 8'((cp >> 6) & 21'h3F), KIND_DATA);
      put_res(8'h80 | 8'(cp & 21'h3F), KIND_DATA);
    end else begin
      put_res(8'hF0 | 8'((cp >> 18) & 21'h07), KIND_DATA);
      put_res(8'h80 | 8'((cp >> 12) & 21'h3F), KIND_DATA);
      put_res(8'h80 | 8'((cp >> 6) & 21'h3F), KIND_DATA);
      put_res(8'h80 | 8'(cp & 21'h3F), KIND_DATA);
    end
  endfunction

  function automatic void put_held();
    put_utf8({5'd0, held_hi});
  endfunction

  function automatic void do_short_escape(logic [7:0] c);
    logic [7:0] b;
    dec_mode = MODE_IDLE;
    case (c)
      CH_QUOTE:  b = CH_QUOTE;
      CH_BSLASH: b = CH_BSLASH;
      CH_SLASH:  b = CH_SLASH;
      CH_B:      b = 8'h08;
      CH_F:      b = 8'h0C;
      CH_N:      b = 8'h0A;
      CH_R:      b = 8'h0D;
      CH_T:      b = 8'h09;
      default: begin
        put_res(8'h00, KIND_BADESC);
        return;
      end
    endcase
    put_res(b, KIND_DATA);
  endfunction

  function automatic void do_plain(logic [7:0] c);
    if (c == CH_QUOTE) begin
      put_res(8'h00, KIND_DONE);
      dec_mode = MODE_IDLE;
    end else if (c == CH_BSLASH) begin
      dec_mode = MODE_ESC;
    end else begin
      put_res(c, KIND_DATA);
      dec_mode = MODE_IDLE;
    end
  endfunction

  function automatic void do_code(logic [15:0] v);
    if (v >= HI_SURR_MIN && v <= HI_SURR_MAX) begin
      held_hi = v;
      dec_mode = MODE_HI;
    end else begin
      put_utf8({5'd0, v});
      dec_mode = MODE_IDLE;
    end
  endfunction

  function automatic void begin_hex(mode_t next_mode);
    hex_cnt = 2'd0;
    code_acc = 16'h0000;
    dec_mode = next_mode;
  endfunction

  function automatic void unescape_step(logic [7:0] c, logic src_end);
    mode_t       m;
    logic [4:0]  d;
    logic [15:0] v;
    logic [20:0] hi_part;
    m = dec_mode;
    step_q.delete();
    if (src_end) begin
      if (m == MODE_HI || m == MODE_HI_ESC || m == MODE_HI_HEX) put_held();
      if (m == MODE_HEX || m == MODE_HI_HEX) put_res(8'h00, KIND_BADU);
      else put_res(8'h00, KIND_UNTERM);
      dec_mode = MODE_IDLE;
      hex_cnt = 2'd0;
    end else begin
      case (m)
        MODE_ESC: begin
          if (c == CH_U) begin_hex(MODE_HEX);
          else do_short_escape(c);
        end
        MODE_HEX, MODE_HI_HEX: begin
          d = hex_of(c);
          if (d[4]) begin
            if (m == MODE_HI_HEX) put_held();
            put_res(8'h00, KIND_BADU);
            dec_mode = MODE_IDLE;
            hex_cnt = 2'd0;
          end else begin
            code_acc = {code_acc[11:0], d[3:0]};
            if (hex_cnt == 2'd3) begin
              hex_cnt = 2'd0;
              v = code_acc;
              if (m == MODE_HI_HEX && v >= LO_SURR_MIN && v <= LO_SURR_MAX) begin
                hi_part = 21'(held_hi - HI_SURR_MIN);
                put_utf8(SUPP_BASE + (hi_part << 10) + 21'(v - LO_SURR_MIN));
                dec_mode = MODE_IDLE;
              end else begin
                if (m == MODE_HI_HEX) put_held();
                do_code(v);
              end
            end else begin
              hex_cnt = hex_cnt + 2'd1;
            end
          end
        end
        MODE_HI: begin
          if (c == CH_BSLASH) begin
            dec_mode = MODE_HI_ESC;
          end else begin
            put_held();
            do_plain(c);
          end
        end
        MODE_HI_ESC: begin
          if (c == CH_U) begin
            begin_hex(MODE_HI_HEX);
          end else begin
            put_held();
            do_short_escape(c);
          end
        end
        default: do_plain(c);
      endcase
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) decoded_q.push_back(step_q[i]);
  endfunction

  function automatic bit calm_now();
    return (($time / 1500) % 4) == 1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm_now()) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n - 4'd10);
  endfunction

  function automatic bit is_escape_letter(logic [7:0] c);
    return c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_B || c == CH_F ||
           c == CH_N || c == CH_R || c == CH_T || c == CH_U;
  endfunction

  task automatic add_byte(logic [7:0] c);
    source_q.push_back('{chr: c, src_end: 1'b0});
  endtask

  task automatic add_end();
    source_q.push_back('{chr: 8'($urandom_range(0, 255)), src_end: 1'b1});
  endtask

  task automatic add_hex_digits(logic [15:0] v, int n);
    for (int i = 0; i < n; i++) add_byte(hex_char(v[15 - 4 * i -: 4]));
  endtask

  task automatic add_u(logic [15:0] v);
    add_byte(CH_BSLASH);
    add_byte(CH_U);
    add_hex_digits(v, 4);
  endtask

  task automatic add_bad_escape();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_escape_letter(c));
    add_byte(CH_BSLASH);
    add_byte(c);
  endtask

  task automatic add_bad_hex(int good_digits);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_of(c) != 5'd16);
    add_byte(CH_BSLASH);
    add_byte(CH_U);
    add_hex_digits(16'($urandom_range(0, 16'hFFFF)), good_digits);
    add_byte(c);
  endtask

  task automatic add_short_escape();
    logic [7:0] letters[8];
    letters = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
    add_byte(CH_BSLASH);
    add_byte(letters[$urandom_range(0, 7)]);
  endtask

  function automatic logic [15:0] rand_code();
    logic [15:0] edges[8];
    edges = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF, 16'hD7FF, 16'hE000};
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 16'h7F));
      1: return 16'($urandom_range(16'h80, 16'h7FF));
      2: return 16'($urandom_range(16'h800, 16'hFFFF));
      3: return edges[$urandom_range(0, 7)];
      default: return 16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX));
    endcase
  endfunction

  function automatic logic [15:0] rand_high();
    return 16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX));
  endfunction

  task automatic add_after_high();
    case ($urandom_range(0, 7))
      0: add_byte(8'($urandom_range(0, 255)));
      1: add_short_escape();
      2: add_u(rand_code());
      3: add_u(rand_high());
      4: add_bad_escape();
      5: add_bad_hex($urandom_range(0, 3));
      6: add_byte(CH_QUOTE);
      default: add_end();
    endcase
  endtask

  task automatic add_end_case();
    int k;
    k = $urandom_range(0, 3);
    case ($urandom_range(0, 5))
      0: ;
      1: add_byte(CH_BSLASH);
      2: begin
        add_byte(CH_BSLASH);
        add_byte(CH_U);
        add_hex_digits(16'($urandom_range(0, 16'hFFFF)), k);
      end
      3: add_u(rand_high());
      4: begin
        add_u(rand_high());
        add_byte(CH_BSLASH);
      end
      default: begin
        add_u(rand_high());
        add_byte(CH_BSLASH);
        add_byte(CH_U);
        add_hex_digits(16'($urandom_range(0, 16'hFFFF)), k);
      end
    endcase
    add_end();
  endtask

  // input side
  int in_gap = 0;
  always @(posedge clk) begin
    src_item_t nxt;
    if (!rst_n) begin
      push <= 1'b0;
      in_byte <= 8'h00;
      in_source_end <= 1'b0;
      in_gap = 0;
    end else begin
      if (push && !full) begin
        unescape_step(in_byte, in_source_end);
        items_taken++;
      end
      if (push && full) begin
        full_cycles++;
      end else if (in_gap > 0) begin
        push <= 1'b0;
        in_gap--;
      end else if (source_q.size() > 0) begin
        nxt = source_q.pop_front();
        in_byte <= nxt.chr;
        in_source_end <= nxt.src_end;
        push <= 1'b1;
        in_gap = pick_gap();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result side: pop pacing, with one long hold to back the block up
  int  out_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      out_gap = 0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else if (!hold_done && results_checked >= 40) begin
      hold_done = 1'b1;
      hold_left = 120;
      pop <= 1'b0;
    end else if (out_gap > 0) begin
      pop <= 1'b0;
      out_gap--;
    end else begin
      pop <= 1'b1;
      out_gap = pick_gap();
    end
  end

  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && pop && !empty) begin
      results_checked++;
      if (out_kind != KIND_DATA) status_seen++;
      if (decoded_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item byte=%02h kind=%0d last=%0b",
                 $time, out_byte, out_kind, out_last);
      end else begin
        want = decoded_q.pop_front();
        if (out_byte !== want.data) begin
          errors++;
          $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte);
        end
        if (out_kind !== want.kind) begin
          errors++;
          $display("%0t: out_kind expected %0d actual %0d", $time, want.kind, out_kind);
        end
        if (out_last !== want.last) begin
          errors++;
          $display("%0t: out_last expected %0b actual %0b", $time, want.last, out_last);
        end
      end
    end
  end

  initial begin
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h41);
    add_byte(CH_QUOTE);
    add_byte(CH_BSLASH);
    add_byte(CH_N);
    add_bad_escape();
    add_u(16'hD800);
    add_u(16'hDC00);
    add_u(16'h0041);
    add_bad_hex(3);
    add_end();
    while (source_q.size() < 205) begin
      case ($urandom_range(0, 13))
        0, 1: add_byte(8'($urandom_range(0, 255)));
        2, 3: add_byte(8'($urandom_range(8'h20, 8'h7E)));
        4: add_short_escape();
        5, 6: add_u(rand_code());
        7, 8: begin
          add_u(rand_high());
          add_u(16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX)));
        end
        9: begin
          add_u(rand_high());
          add_after_high();
        end
        10: add_bad_escape();
        11: add_bad_hex($urandom_range(0, 3));
        12: add_byte(CH_QUOTE);
        default: add_end_case();
      endcase
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (source_q.size() != 0 || push) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d input items and %0d results, %0d of them status reports",
             items_taken, results_checked, status_seen);
    $display("input held off by full for %0d cycles", full_cycles);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
